/* hw/rtl/shbi_pkg.sv */
// Shared types and constants for the string hash bucket index block.
// No dependencies; imported by every module of the block.
`default_nettype none

package shbi_pkg;

    localparam int HASH_W    = 32;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_CNT_W = $clog2(HASH_W);

    localparam logic [CFG_IDX_W-1:0] REG_HASH_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUCKET_COUNT = 2'd1;

    localparam logic              MODE_MULT31  = 1'b0;
    localparam logic              MODE_JOAAT   = 1'b1;
    localparam logic [HASH_W-1:0] BUCKET_RESET = 32'd65521;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = DIV_CNT_W'(HASH_W - 1);

    typedef struct packed {
        logic fold;      // fold the accepted byte into the running hash
        logic finish;    // final mix (JOAAT mode), clear running hash, prime divider
        logic div_step;  // one restoring division step
        logic load_out;  // move hash and remainder into the output register
    } shbi_cmd_t;

    typedef struct packed {
        logic out_full;  // output register holds an untaken result
    } shbi_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/shbi_ctrl.sv */
// Controller FSM: sequences byte fold, final mix, bit-serial modulo and output load.
// Depends on shbi_pkg.
`default_nettype none

module shbi_ctrl
    import shbi_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire logic      s_tlast,
    input  wire logic      byte_present,
    input  wire shbi_sts_t sts,
    input  wire logic      m_tready,
    output shbi_cmd_t      cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_FIN  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd.fold     = 1'b0;
        cmd.finish   = 1'b0;
        cmd.div_step = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.fold = byte_present;
                    if (s_tlast) begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                cmd.finish = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST_STEP) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!sts.out_full || m_tready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/shbi_dp.sv */
// Datapath: config registers, running hash, final mix, restoring remainder unit,
// output register. Depends on shbi_pkg.
`default_nettype none

module shbi_dp
    import shbi_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [HASH_W-1:0]    cfg_data,
    input  wire logic [BYTE_W-1:0]    key_byte,
    input  wire shbi_cmd_t            cmd,
    output shbi_sts_t                 sts,
    input  wire logic                 m_tready,
    output logic                      m_tvalid,
    output logic [HASH_W-1:0]         raw_hash,
    output logic [HASH_W-1:0]         bucket_index
);

    logic              mode_reg;
    logic [HASH_W-1:0] bucket_reg;
    logic [HASH_W-1:0] hash_reg, hash_next;
    logic [HASH_W-1:0] raw_reg;
    logic [HASH_W-1:0] dvd_reg;
    logic [HASH_W-1:0] rem_reg, rem_next;
    logic [HASH_W-1:0] out_raw_reg, out_idx_reg;
    logic              out_vld_reg;

    logic [HASH_W-1:0] j_add, j_mix, f_a, f_b, f_c;
    logic [HASH_W:0]   shifted, diff;

    // byte fold
    always_comb begin
        j_add = hash_reg + {{(HASH_W-BYTE_W){1'b0}}, key_byte};
        j_mix = j_add + (j_add << 10);
        j_mix = j_mix ^ (j_mix >> 6);
        if (mode_reg == MODE_JOAAT) begin
            hash_next = j_mix;
        end else begin
            hash_next = (hash_reg << 5) - hash_reg + {{(HASH_W-BYTE_W){1'b0}}, key_byte};
        end
    end

    // final mix
    always_comb begin
        f_a = hash_reg + (hash_reg << 3);
        f_b = f_a ^ (f_a >> 11);
        f_c = f_b + (f_b << 15);
    end

    // one remainder bit per step; a zero divisor leaves the dividend as remainder
    always_comb begin
        shifted  = {rem_reg, dvd_reg[HASH_W-1]};
        diff     = shifted - {1'b0, bucket_reg};
        rem_next = diff[HASH_W] ? shifted[HASH_W-1:0] : diff[HASH_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_JOAAT;
            bucket_reg <= BUCKET_RESET;
        end else if (cfg_wr) begin
            case (cfg_index)
                REG_HASH_MODE:    mode_reg   <= cfg_data[0];
                REG_BUCKET_COUNT: bucket_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg <= '0;
        end else if (cmd.fold) begin
            hash_reg <= hash_next;
        end else if (cmd.finish) begin
            hash_reg <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            raw_reg <= (mode_reg == MODE_JOAAT) ? f_c : hash_reg;
            dvd_reg <= (mode_reg == MODE_JOAAT) ? f_c : hash_reg;
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_raw_reg <= raw_reg;
            out_idx_reg <= rem_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    assign sts.out_full = out_vld_reg;
    assign m_tvalid     = out_vld_reg;
    assign raw_hash     = out_raw_reg;
    assign bucket_index = out_idx_reg;

endmodule

`default_nettype wire

/* hw/rtl/string_hash_bucket_index.sv */
// Top level of the string hash bucket index block: joins controller and datapath.
// Depends on shbi_pkg, shbi_ctrl, shbi_dp.
//
// channel  direction  handshake              payload
// s_       in         s_tvalid / s_tready    tdata key byte, tuser byte present, tlast key end
// m_       out        m_tvalid / m_tready    tdata raw hash, bucket index
// cfg_     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A byte that does not end a key leaves the controller idle and ready for the next byte.
// After a key end the input is not ready again until the final mix, the bit-serial
// remainder unit (one bit per cycle) and the output register load have run.
// aresetn (synchronous) restores hash_mode 1, bucket_count 65521, running hash 0.
// A result waiting in the output register does not block new bytes; only the
// next key end waits for it to be taken.
`default_nettype none

module string_hash_bucket_index
    import shbi_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // [7:0] key_byte
    input  wire logic [0:0]           s_tuser,   // [0] byte_present
    input  wire logic                 s_tlast,   // key_last
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [63:0]               m_tdata,   // [31:0] raw_hash, [63:32] bucket_index
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [HASH_W-1:0]    cfg_data
);

    shbi_cmd_t         cmd;
    shbi_sts_t         sts;
    logic [HASH_W-1:0] raw_hash, bucket_index;

    assign cfg_ready = 1'b1;
    assign m_tdata   = {bucket_index, raw_hash};

    shbi_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tlast      (s_tlast),
        .byte_present (s_tuser[0]),
        .sts          (sts),
        .m_tready     (m_tready),
        .cmd          (cmd)
    );

    shbi_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .key_byte     (s_tdata),
        .cmd          (cmd),
        .sts          (sts),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .raw_hash     (raw_hash),
        .bucket_index (bucket_index)
    );

endmodule

`default_nettype wire

/* sim/string_hash_bucket_index_tb.sv */
// Self-checking testbench for string_hash_bucket_index: streams keys byte by byte,
// rewrites hash mode and bucket count, also mid-key, checks every hash and bucket.
// Depends on shbi_pkg and the string_hash_bucket_index RTL.

module string_hash_bucket_index_tb;
    import shbi_pkg::*;

    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 3000;
    localparam int ITEM_TARGET  = 1350;
    localparam int CALM_AFTER   = 1200;
    localparam int HOLD_CYCLES  = 400;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        logic [HASH_W-1:0] raw;
        logic [HASH_W-1:0] idx;
    } hash_result_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [HASH_W-1:0]     value;
        logic [BYTE_W-1:0]     key_byte;
        logic                  present;
        logic                  last;
        logic                  typed;
        logic [HASH_W-1:0]     raw;
        logic [HASH_W-1:0]     idx;
    } dir_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;   // [7:0] key_byte
    logic [0:0]            s_tuser;   // [0] byte_present
    logic                  s_tlast;   // key_last
    logic                  m_tvalid;
    logic                  m_tready;
    logic [63:0]           m_tdata;   // [31:0] raw_hash, [63:32] bucket_index
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [HASH_W-1:0]     cfg_data;

    hash_result_t      pending_hashes[$];
    dir_row_t          dir_rows[$];
    logic [HASH_W-1:0] pred_hash;
    logic              pred_mode;
    logic [HASH_W-1:0] pred_buckets;
    int                errors;
    int                items_sent;
    int                hold_len;
    int                stall_cycles;
    bit                calm;

    string_hash_bucket_index dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic [HASH_W-1:0] mix_in_byte(logic [HASH_W-1:0] h,
                                                     logic [BYTE_W-1:0] b, logic mode);
        if (mode == MODE_MULT31)
            return h * 32'd31 + {24'd0, b};
        h = h + {24'd0, b};
        h = h + (h << 10);
        h = h ^ (h >> 6);
        return h;
    endfunction

    function automatic logic [HASH_W-1:0] close_hash(logic [HASH_W-1:0] h, logic mode);
        if (mode == MODE_JOAAT) begin
            h = h + (h << 3);
            h = h ^ (h >> 11);
            h = h + (h << 15);
        end
        return h;
    endfunction

    function automatic logic [HASH_W-1:0] pick_buckets();
        case ($urandom_range(0, 6))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'hFFFF_FFFF;
            3: return 32'($urandom_range(2, 16));
            4: return 32'($urandom_range(17, 70000));
            5: return 32'h8000_0000 | 32'($urandom);
            default: return 32'($urandom);
        endcase
    endfunction

    function automatic dir_row_t item_row(logic [7:0] kb, logic pr, logic ls);
        return '{ROW_ITEM, REG_HASH_MODE, 32'd0, kb, pr, ls, 1'b0, 32'd0, 32'd0};
    endfunction

    function automatic dir_row_t typed_row(logic [7:0] kb, logic pr, logic ls,
                                           logic [31:0] raw, logic [31:0] idx);
        return '{ROW_ITEM, REG_HASH_MODE, 32'd0, kb, pr, ls, 1'b1, raw, idx};
    endfunction

    function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] ri, logic [31:0] val);
        return '{ROW_CFG, ri, val, 8'd0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0};
    endfunction

    // one transfer on the key stream, fold a present byte into the predicted hash, queue the result on a key end
    task automatic send_item(input logic [7:0] kb, input logic present, input logic last,
                             input bit counted, input logic typed,
                             input logic [31:0] t_raw, input logic [31:0] t_idx);
        hash_result_t res;
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= kb;
        s_tuser  <= present;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        if (counted)
            items_sent++;
        if (present)
            pred_hash = mix_in_byte(pred_hash, kb, pred_mode);
        if (last) begin
            res.raw = close_hash(pred_hash, pred_mode);
            res.idx = (pred_buckets == 0) ? res.raw : res.raw % pred_buckets;
            pred_hash = '0;
            if (typed) begin
                res.raw = t_raw;
                res.idx = t_idx;
            end
            pending_hashes.push_back(res);
        end
    endtask

    // register writes only once the block has drained
    task automatic write_reg(input logic [CFG_IDX_W-1:0] ri, input logic [31:0] val);
        s_tvalid <= 1'b0;
        while (pending_hashes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= ri;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (ri == REG_HASH_MODE)
            pred_mode = val[0];
        else if (ri == REG_BUCKET_COUNT)
            pred_buckets = val;
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin
        m_tready = 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (hold_len > 0) begin
                m_tready <= 1'b0;
                repeat (hold_len) @(posedge aclk);
                hold_len = 0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        hash_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_hashes.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual raw %h bucket %h",
                         $time, m_tdata[31:0], m_tdata[63:32]);
                errors++;
            end else begin
                want = pending_hashes.pop_front();
                if (m_tdata[31:0] !== want.raw) begin
                    $display("%0t: raw_hash mismatch, expected %h, actual %h",
                             $time, want.raw, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[63:32] !== want.idx) begin
                    $display("%0t: bucket_index mismatch, expected %h, actual %h",
                             $time, want.idx, m_tdata[63:32]);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        int klen;
        int kcount;
        int n;
        logic lastp;
        aclk         = 1'b0;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        s_tlast      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_HASH_MODE;
        cfg_data     = '0;
        errors       = 0;
        items_sent   = 0;
        hold_len     = 0;
        stall_cycles = 0;
        calm         = 1'b0;
        kcount       = 0;
        pred_hash    = '0;
        pred_mode    = MODE_JOAAT;
        pred_buckets = BUCKET_RESET;

        // empty keys, skipped bytes, zero bucket count, extremes, mode switch mid-key
        dir_rows.push_back(typed_row(8'h00, 1'b0, 1'b1, 32'd0, 32'd0));
        dir_rows.push_back(typed_row(8'hFF, 1'b0, 1'b1, 32'd0, 32'd0));
        dir_rows.push_back(item_row(8'h41, 1'b1, 1'b0));
        dir_rows.push_back(item_row(8'h00, 1'b0, 1'b0));
        dir_rows.push_back(item_row(8'h42, 1'b1, 1'b1));
        dir_rows.push_back(item_row(8'hFF, 1'b1, 1'b1));
        dir_rows.push_back(typed_row(8'h00, 1'b1, 1'b1, 32'd0, 32'd0));
        dir_rows.push_back(item_row(8'h61, 1'b1, 1'b0));
        dir_rows.push_back(item_row(8'h62, 1'b1, 1'b0));
        dir_rows.push_back(item_row(8'h63, 1'b0, 1'b1));
        dir_rows.push_back(cfg_row(REG_HASH_MODE, {31'd0, MODE_MULT31}));
        dir_rows.push_back(cfg_row(REG_BUCKET_COUNT, 32'd0));
        dir_rows.push_back(typed_row(8'hFF, 1'b1, 1'b1, 32'd255, 32'd255));
        dir_rows.push_back(typed_row(8'h00, 1'b0, 1'b1, 32'd0, 32'd0));
        dir_rows.push_back(item_row(8'h01, 1'b1, 1'b0));
        dir_rows.push_back(typed_row(8'h80, 1'b1, 1'b1, 32'd159, 32'd159));
        dir_rows.push_back(cfg_row(REG_BUCKET_COUNT, 32'hFFFF_FFFF));
        dir_rows.push_back(typed_row(8'hFF, 1'b1, 1'b1, 32'd255, 32'd255));
        dir_rows.push_back(cfg_row(REG_BUCKET_COUNT, 32'd1));
        dir_rows.push_back(typed_row(8'h7F, 1'b1, 1'b1, 32'd127, 32'd0));
        repeat (4) dir_rows.push_back(item_row(8'hFF, 1'b1, 1'b0));
        dir_rows.push_back(item_row(8'hFF, 1'b1, 1'b1));
        dir_rows.push_back(item_row(8'h55, 1'b1, 1'b0));
        dir_rows.push_back(cfg_row(REG_HASH_MODE, {31'd0, MODE_JOAAT}));
        dir_rows.push_back(cfg_row(REG_BUCKET_COUNT, 32'h8000_0000));
        dir_rows.push_back(item_row(8'hAA, 1'b1, 1'b1));
        dir_rows.push_back(item_row(8'h33, 1'b1, 1'b0));
        dir_rows.push_back(cfg_row(REG_HASH_MODE, {31'd0, MODE_MULT31}));
        dir_rows.push_back(item_row(8'hCC, 1'b1, 1'b1));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG)
                write_reg(dir_rows[r].reg_idx, dir_rows[r].value);
            else
                send_item(dir_rows[r].key_byte, dir_rows[r].present, dir_rows[r].last,
                          1'b1, dir_rows[r].typed, dir_rows[r].raw, dir_rows[r].idx);
        end

        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= CALM_AFTER)
                calm = 1'b1;
            if (kcount == 30)
                hold_len = HOLD_CYCLES;
            if (kcount == 60) begin
                s_tvalid <= 1'b0;
                while (pending_hashes.size() != 0) @(posedge aclk);
            end
            // no register writes during the long hold-off, so the block fills up
            if (hold_len == 0 && $urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 2))
                    0: write_reg(REG_HASH_MODE, {31'd0, 1'($urandom_range(0, 1))});
                    1: write_reg(REG_BUCKET_COUNT, pick_buckets());
                    default: begin
                        write_reg(REG_HASH_MODE, {31'd0, 1'($urandom_range(0, 1))});
                        write_reg(REG_BUCKET_COUNT, pick_buckets());
                    end
                endcase
            end
            klen = ($urandom_range(0, 19) == 0) ? $urandom_range(11, 40)
                                                : $urandom_range(0, 10);
            for (n = 0; n < klen; n++) begin
                if ($urandom_range(0, 7) == 0)
                    send_item(8'($urandom), 1'b0, 1'b0, 1'b1, 1'b0, 32'd0, 32'd0);
                send_item(8'($urandom), 1'b1, 1'b0, 1'b1, 1'b0, 32'd0, 32'd0);
                if (hold_len == 0 && $urandom_range(0, 39) == 0)
                    write_reg(REG_HASH_MODE, {31'd0, 1'($urandom_range(0, 1))});
            end
            lastp = ($urandom_range(0, 3) != 0);
            send_item(8'($urandom), lastp, 1'b1, 1'b1, 1'b0, 32'd0, 32'd0);
            kcount++;
        end

        s_tvalid <= 1'b0;
        while (pending_hashes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/shbi_pkg.sv
hw/rtl/shbi_ctrl.sv
hw/rtl/shbi_dp.sv
hw/rtl/string_hash_bucket_index.sv
sim/string_hash_bucket_index_tb.sv
